FILE: rtl/core/yp2rgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yp2rgb_pkg
// Shared types, constants and helpers for the YUV pair to RGB converter.
// ----------------------------------------------------------------------------
package yp2rgb_pkg;

    localparam int SUM_W = 20;
    localparam int PROD_W = 18;

    // source format codes; code 3 behaves as an 8-bit mode
    localparam logic [1:0] FMT_NV12 = 2'd0;
    localparam logic [1:0] FMT_YUY2 = 2'd1;
    localparam logic [1:0] FMT_Y210 = 2'd2;

    localparam logic signed [PROD_W-1:0] COEF_Y  = 18'sd298;
    localparam logic signed [PROD_W-1:0] COEF_RV = 18'sd409;
    localparam logic signed [PROD_W-1:0] COEF_GU = 18'sd100;
    localparam logic signed [PROD_W-1:0] COEF_GV = 18'sd208;
    localparam logic signed [PROD_W-1:0] COEF_BU = 18'sd516;
    localparam logic signed [8:0] Y_OFFSET = 9'sd16;
    localparam logic signed [8:0] C_OFFSET = 9'sd128;
    localparam logic signed [SUM_W-1:0] ROUND = 20'sd128;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
    } yuv_t;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } rgb_t;

    // (s*255+511)/1023; x/1023 == (x + (x>>10) + 1) >> 10 for this range
    function automatic logic [7:0] scale10(input logic [9:0] s);
        logic [17:0] x;
        logic [17:0] t;
        begin
            x = {s, 8'b0} - {8'b0, s} + 18'd511;
            t = x + {10'b0, x[17:10]} + 18'd1;
            return t[17:10];
        end
    endfunction

    // floor(sum/256) clamped to 0..255
    function automatic logic [7:0] clamp8(input sum_t sum);
        begin
            if (sum[SUM_W-1])
                return 8'd0;
            else if (sum[SUM_W-2:16] != '0)
                return 8'd255;
            else
                return sum[15:8];
        end
    endfunction

endpackage

FILE: rtl/core/yuv_pair_to_rgb_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_pair_to_rgb_converter_core
// BT.601 limited-range YUV 4:2:2 pixel pair to two RGB888 pixels.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel pair per request: tdata holds luma_first,
//   luma_second, chroma_u, chroma_v (10 bits each), tuser holds second_present.
//   m_axis returns the two RGB pixels in tdata and second_valid in tuser;
//   an absent second pixel reads as zero.
//   cfg_we/cfg_wdata load the pixel format (0 NV12, 1 YUY2, 2 Y210); write it
//   only while the pipeline is empty.
// Timing:
//   Four register stages: scale, multiply, sum, clamp/output. One pair per
//   clock is sustained while the output is not stalled. The pipeline
//   advances as a whole.
// Reset and stall:
//   rst_n clears all valid bits and sets the pixel format to NV12. While the
//   output holds an untaken request every stage freezes and s_axis_tready
//   drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module yuv_pair_to_rgb_converter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,      // pixel format
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // luma_first[9:0], luma_second[19:10], chroma_u[29:20], chroma_v[39:30]
    input  logic [39:0] s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,   // second_present
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red_first, green_first, blue_first, red_second, green_second,
    // blue_second, 8 bits each from bit 0 up
    output logic [47:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser    // second_valid
);
    import yp2rgb_pkg::*;

    logic [1:0] fmt_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic s1_reg, s2_reg, s3_reg, s4_reg;
    logic en;
    yuv_t pix_first, pix_second;
    sum_t r0, g0, b0, r1, g1, b1;
    rgb_t rgb_first, rgb_second;

    assign en = !v4_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= FMT_NV12;
        else if (cfg_we)
            fmt_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s_axis_tuser[0];
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            s4_reg <= s3_reg;
        end
    end

    yp2rgb_input_scale u_scale (
        .clk            (clk),
        .en             (en),
        .pix_format     (fmt_reg),
        .luma_first     (s_axis_tdata[9:0]),
        .luma_second    (s_axis_tdata[19:10]),
        .chroma_u       (s_axis_tdata[29:20]),
        .chroma_v       (s_axis_tdata[39:30]),
        .second_present (s_axis_tuser[0]),
        .pix_first      (pix_first),
        .pix_second     (pix_second)
    );

    yp2rgb_matrix u_matrix_first (
        .clk   (clk),
        .en    (en),
        .pix   (pix_first),
        .sum_r (r0),
        .sum_g (g0),
        .sum_b (b0)
    );

    yp2rgb_matrix u_matrix_second (
        .clk   (clk),
        .en    (en),
        .pix   (pix_second),
        .sum_r (r1),
        .sum_g (g1),
        .sum_b (b1)
    );

    yp2rgb_clamp u_clamp_first (
        .clk   (clk),
        .en    (en),
        .keep  (1'b1),
        .sum_r (r0),
        .sum_g (g0),
        .sum_b (b0),
        .rgb   (rgb_first)
    );

    yp2rgb_clamp u_clamp_second (
        .clk   (clk),
        .en    (en),
        .keep  (s3_reg),
        .sum_r (r1),
        .sum_g (g1),
        .sum_b (b1),
        .rgb   (rgb_second)
    );

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata = {rgb_second.b, rgb_second.g, rgb_second.r,
                           rgb_first.b, rgb_first.g, rgb_first.r};
    assign m_axis_tuser = s4_reg;

    a_stall_freezes_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> v1_reg)
        else $error("accepted request not in first stage");

    a_out_from_stage3: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(v3_reg))
        else $error("output valid without a request in stage 3");

    a_absent_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[47:24] == 24'd0)
        else $error("absent second pixel not blanked");

endmodule

FILE: rtl/core/yp2rgb_input_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yp2rgb_input_scale
// First stage: format decode and, for Y210, 10-to-8 bit scaling of the sample pair.
// ----------------------------------------------------------------------------
module yp2rgb_input_scale (
    input  logic               clk,
    input  logic               en,
    input  logic [1:0]         pix_format,
    input  logic [9:0]         luma_first,
    input  logic [9:0]         luma_second,
    input  logic [9:0]         chroma_u,
    input  logic [9:0]         chroma_v,
    input  logic               second_present,
    output yp2rgb_pkg::yuv_t   pix_first,
    output yp2rgb_pkg::yuv_t   pix_second
);
    import yp2rgb_pkg::*;

    yuv_t first_reg, first_next;
    yuv_t second_reg, second_next;
    logic [7:0] u_s;

    always_comb
    begin
        u_s = scale10(chroma_u);
        if (pix_format == FMT_Y210)
        begin
            first_next.y = scale10(luma_first);
            second_next.y = scale10(luma_second);
            first_next.u = u_s;
            first_next.v = second_present ? scale10(chroma_v) : u_s;
        end
        else
        begin
            first_next.y = luma_first[7:0];
            second_next.y = luma_second[7:0];
            first_next.u = chroma_u[7:0];
            first_next.v = chroma_v[7:0];
        end
        second_next.u = first_next.u;
        second_next.v = first_next.v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            first_reg <= first_next;
            second_reg <= second_next;
        end
    end

    assign pix_first = first_reg;
    assign pix_second = second_reg;

endmodule

FILE: rtl/core/yp2rgb_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yp2rgb_matrix
// Two stages of the BT.601 transform for one pixel: products, then sums.
// ----------------------------------------------------------------------------
module yp2rgb_matrix (
    input  logic               clk,
    input  logic               en,
    input  yp2rgb_pkg::yuv_t   pix,
    output yp2rgb_pkg::sum_t   sum_r,
    output yp2rgb_pkg::sum_t   sum_g,
    output yp2rgb_pkg::sum_t   sum_b
);
    import yp2rgb_pkg::*;

    logic signed [8:0] c, d, e;
    prod_t cx, dx, ex;
    prod_t py_reg, py_next;
    prod_t pr_reg, pr_next;
    prod_t pg_reg, pg_next;
    prod_t pb_reg, pb_next;
    sum_t r_reg, r_next;
    sum_t g_reg, g_next;
    sum_t b_reg, b_next;

    always_comb
    begin
        c = $signed({1'b0, pix.y}) - Y_OFFSET;
        d = $signed({1'b0, pix.u}) - C_OFFSET;
        e = $signed({1'b0, pix.v}) - C_OFFSET;
        cx = PROD_W'(c);
        dx = PROD_W'(d);
        ex = PROD_W'(e);
        py_next = cx * COEF_Y;
        pr_next = ex * COEF_RV;
        pg_next = dx * COEF_GU + ex * COEF_GV;
        pb_next = dx * COEF_BU;
    end

    always_comb
    begin
        r_next = SUM_W'(py_reg) + SUM_W'(pr_reg) + ROUND;
        g_next = SUM_W'(py_reg) - SUM_W'(pg_reg) + ROUND;
        b_next = SUM_W'(py_reg) + SUM_W'(pb_reg) + ROUND;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            py_reg <= py_next;
            pr_reg <= pr_next;
            pg_reg <= pg_next;
            pb_reg <= pb_next;
            r_reg <= r_next;
            g_reg <= g_next;
            b_reg <= b_next;
        end
    end

    assign sum_r = r_reg;
    assign sum_g = g_reg;
    assign sum_b = b_reg;

endmodule

FILE: rtl/core/yp2rgb_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yp2rgb_clamp
// Output stage: shift, clamp to 8 bits and blank an absent pixel.
// ----------------------------------------------------------------------------
module yp2rgb_clamp (
    input  logic               clk,
    input  logic               en,
    input  logic               keep,
    input  yp2rgb_pkg::sum_t   sum_r,
    input  yp2rgb_pkg::sum_t   sum_g,
    input  yp2rgb_pkg::sum_t   sum_b,
    output yp2rgb_pkg::rgb_t   rgb
);
    import yp2rgb_pkg::*;

    rgb_t rgb_reg, rgb_next;

    always_comb
    begin
        if (keep)
        begin
            rgb_next.r = clamp8(sum_r);
            rgb_next.g = clamp8(sum_g);
            rgb_next.b = clamp8(sum_b);
        end
        else
        begin
            rgb_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rgb_reg <= rgb_next;
    end

    assign rgb = rgb_reg;

endmodule
